FILE: sv/gcb_pkg.sv
`default_nettype none
package gcb_pkg;
    localparam int COORD_FRAC_BITS = 20;
    localparam int CORDIC_STAGES   = 24;

    // phase = trunc(|v| * 2^(32-F) / 360) = trunc(|v| * 2^K / 45), K = 29 - F
    localparam int     PH_K    = 29 - COORD_FRAC_BITS;
    localparam longint PH_QK   = (longint'(1) << PH_K) / 45;
    localparam longint PH_RK   = (longint'(1) << PH_K) % 45;
    localparam longint RECIP_M = (PH_RK << 30) / 45;

    localparam int ABS_W = 30;
    localparam int PH_W  = 32;
    localparam int SC_W  = 33;
    localparam int SCZ_W = 34;
    localparam int PR_W  = 36;
    localparam int VEC_W = 40;
    localparam int DEG_W = 9;

    localparam logic signed [SC_W-1:0] CORDIC_GAIN = 33'sd652032874;

    localparam logic [31:0] ATAN_TAB [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
        32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
    };

    localparam int GCB_LATENCY = 3 + (CORDIC_STAGES + 2) + 3 + (CORDIC_STAGES + 2);

    typedef struct packed {
        logic zero_both;
        logic south;
        logic ypos;
        logic yneg;
    } gcb_flags_t;
endpackage
`default_nettype wire

FILE: sv/gcb_sincos.sv
`default_nettype none
module gcb_sincos import gcb_pkg::*; (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    input  wire logic [PH_W-1:0]        phase,
    output logic                        out_valid,
    output logic signed [SC_W-1:0]      sin_q,
    output logic signed [SC_W-1:0]      cos_q
);
    logic signed [SC_W-1:0]  x_reg [CORDIC_STAGES+1];
    logic signed [SC_W-1:0]  y_reg [CORDIC_STAGES+1];
    logic signed [SCZ_W-1:0] z_reg [CORDIC_STAGES+1];
    logic [CORDIC_STAGES:0]  flip_reg;
    logic [CORDIC_STAGES:0]  v_reg;
    logic                    flip_next;
    logic [PH_W-1:0]         pp_next;
    logic                    out_valid_reg;
    logic signed [SC_W-1:0]  sin_reg;
    logic signed [SC_W-1:0]  cos_reg;

    // fold the left half plane onto the right one
    assign flip_next = phase[PH_W-1] ^ phase[PH_W-2];
    assign pp_next   = flip_next ? (phase + 32'h8000_0000) : phase;

    always_ff @(posedge clk)
    begin
        x_reg[0]    <= CORDIC_GAIN;
        y_reg[0]    <= '0;
        z_reg[0]    <= SCZ_W'(signed'(pp_next));
        flip_reg[0] <= flip_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= in_valid;
        end
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_stage
        always_ff @(posedge clk)
        begin
            if (!z_reg[i][SCZ_W-1])
            begin
                x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] - SCZ_W'(ATAN_TAB[i]);
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] + SCZ_W'(ATAN_TAB[i]);
            end
            flip_reg[i+1] <= flip_reg[i];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i+1] <= 1'b0;
            end
            else
            begin
                v_reg[i+1] <= v_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sin_reg <= flip_reg[CORDIC_STAGES] ? -y_reg[CORDIC_STAGES] : y_reg[CORDIC_STAGES];
        cos_reg <= flip_reg[CORDIC_STAGES] ? -x_reg[CORDIC_STAGES] : x_reg[CORDIC_STAGES];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= v_reg[CORDIC_STAGES];
        end
    end

    assign out_valid = out_valid_reg;
    assign sin_q     = sin_reg;
    assign cos_q     = cos_reg;
endmodule
`default_nettype wire

FILE: sv/gcb_atan2.sv
`default_nettype none
module gcb_atan2 import gcb_pkg::*; (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    input  wire logic signed [PR_W-1:0] y_in,
    input  wire logic signed [PR_W-1:0] x_in,
    output logic                        out_valid,
    output logic signed [DEG_W-1:0]     deg
);
    logic signed [VEC_W-1:0] vx_reg [CORDIC_STAGES+1];
    logic signed [VEC_W-1:0] vy_reg [CORDIC_STAGES+1];
    logic [PH_W-1:0]         vz_reg [CORDIC_STAGES+1];
    gcb_flags_t              fl_reg [CORDIC_STAGES+1];
    logic [CORDIC_STAGES:0]  v_reg;
    gcb_flags_t              fl_next;
    logic signed [VEC_W-1:0] xe;
    logic signed [VEC_W-1:0] ye;
    logic signed [PH_W-1:0]  p;
    logic signed [40:0]      m;
    logic [40:0]             mag;
    logic signed [DEG_W-1:0] d;
    logic signed [DEG_W-1:0] deg_next;
    gcb_flags_t              fl_end;
    logic signed [DEG_W-1:0] deg_reg;
    logic                    out_valid_reg;

    assign xe = VEC_W'(x_in);
    assign ye = VEC_W'(y_in);

    always_comb
    begin
        fl_next.zero_both = (x_in == '0) && (y_in == '0);
        fl_next.south     = (y_in == '0) && x_in[PR_W-1];
        fl_next.ypos      = !y_in[PR_W-1] && (y_in != '0);
        fl_next.yneg      = y_in[PR_W-1];
    end

    // start in the right half plane; a left-half vector carries half a turn
    always_ff @(posedge clk)
    begin
        vx_reg[0] <= x_in[PR_W-1] ? -xe : xe;
        vy_reg[0] <= x_in[PR_W-1] ? -ye : ye;
        vz_reg[0] <= x_in[PR_W-1] ? 32'h8000_0000 : 32'h0;
        fl_reg[0] <= fl_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= in_valid;
        end
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_stage
        always_ff @(posedge clk)
        begin
            if (!vy_reg[i][VEC_W-1])
            begin
                vx_reg[i+1] <= vx_reg[i] + (vy_reg[i] >>> i);
                vy_reg[i+1] <= vy_reg[i] - (vx_reg[i] >>> i);
                vz_reg[i+1] <= vz_reg[i] + ATAN_TAB[i];
            end
            else
            begin
                vx_reg[i+1] <= vx_reg[i] - (vy_reg[i] >>> i);
                vy_reg[i+1] <= vy_reg[i] + (vx_reg[i] >>> i);
                vz_reg[i+1] <= vz_reg[i] - ATAN_TAB[i];
            end
            fl_reg[i+1] <= fl_reg[i];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i+1] <= 1'b0;
            end
            else
            begin
                v_reg[i+1] <= v_reg[i];
            end
        end
    end

    // phase to whole degrees, truncated toward zero, then the wrap fixes
    always_comb
    begin
        fl_end = fl_reg[CORDIC_STAGES];
        p      = signed'(vz_reg[CORDIC_STAGES]);
        m      = 41'(p) * 41'sd360;
        mag    = m[40] ? 41'(-m) : 41'(m);
        d      = signed'(mag[40:32]);
        deg_next = m[40] ? -d : d;
        if (fl_end.ypos && deg_next[DEG_W-1])
        begin
            deg_next = 9'sd179;
        end
        if (fl_end.yneg && !deg_next[DEG_W-1] && (deg_next != '0))
        begin
            deg_next = -9'sd179;
        end
        if (fl_end.south)
        begin
            deg_next = 9'sd180;
        end
        if (fl_end.zero_both)
        begin
            deg_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        deg_reg <= deg_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= v_reg[CORDIC_STAGES];
        end
    end

    assign out_valid = out_valid_reg;
    assign deg       = deg_reg;
endmodule
`default_nettype wire

FILE: sv/great_circle_bearing_core.sv
// Initial great-circle bearing from a current to a destination position.
//
// Input channel: raise start for one cycle with cur_lat, cur_lon, dest_lat and
// dest_lon; the beat is taken at the rising edge where start is high and busy
// is low. busy is always low, so a new beat may be taken every cycle.
// Positions are signed degrees with 20 fraction bits.
//
// Result channel: done is high for exactly one cycle with bearing_deg, the
// bearing in whole degrees (-180..180, clockwise from north, truncated toward
// zero). The receiver cannot stall, so results leave as they are made.
//
// Path: the accepted beat passes through degree-to-phase conversion (magnitude
// and sign, reciprocal estimate, corrected signed phase), a sine/cosine CORDIC
// pipeline (three lanes side by side), registered products, and an atan2
// CORDIC pipeline with degree scaling. Throughput is one beat per cycle; the
// CORDIC stage count sets the depth.
//
// Reset clears every valid bit, so beats in flight are dropped and no
// result appears until new beats arrive.
`default_nettype none
module great_circle_bearing_core import gcb_pkg::*; (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [27:0] cur_lat,
    input  wire logic signed [28:0] cur_lon,
    input  wire logic signed [27:0] dest_lat,
    input  wire logic signed [28:0] dest_lon,
    output logic                    busy,
    output logic                    done,
    output logic signed [8:0]       bearing_deg
);
    logic signed [ABS_W-1:0] src [3];
    logic [ABS_W-1:0]        abs_reg [3];
    logic [2:0]              neg1_reg;
    logic [ABS_W-1:0]        q0_reg [3];
    logic [ABS_W-1:0]        a2_reg [3];
    logic [2:0]              neg2_reg;
    logic [PH_W-1:0]         phase_reg [3];
    logic                    v1_reg;
    logic                    v2_reg;
    logic                    v3_reg;

    logic [2:0]              sc_v;
    logic signed [SC_W-1:0]  sin_w [3];
    logic signed [SC_W-1:0]  cos_w [3];
    logic                    sc_valid;

    logic signed [2*SC_W-1:0] p_y;
    logic signed [2*SC_W-1:0] p_t;
    logic signed [2*SC_W-1:0] p_x;
    logic signed [2*SC_W-1:0] p_tc;
    logic signed [PR_W-1:0]   my_reg;
    logic signed [SC_W-1:0]   t_reg;
    logic signed [PR_W-1:0]   c1s2_reg;
    logic signed [SC_W-1:0]   cd_reg;
    logic signed [PR_W-1:0]   y2_reg;
    logic signed [PR_W-1:0]   x1_reg;
    logic signed [PR_W-1:0]   tc_reg;
    logic signed [PR_W-1:0]   y3_reg;
    logic signed [PR_W-1:0]   x3_reg;
    logic                     m1_v_reg;
    logic                     m2_v_reg;
    logic                     m3_v_reg;

    logic                     start_ok;

    assign busy     = 1'b0;
    assign start_ok = start && !busy;

    // lane 0: current latitude, lane 1: destination latitude, lane 2: dlon
    assign src[0] = ABS_W'(cur_lat);
    assign src[1] = ABS_W'(dest_lat);
    assign src[2] = ABS_W'(dest_lon) - ABS_W'(cur_lon);

    for (genvar k = 0; k < 3; k++)
    begin : g_lane
        logic [PR_W-1:0] r;
        logic [PH_W-1:0] q1;
        logic [PH_W-1:0] q;

        // stage 1: magnitude and sign
        always_ff @(posedge clk)
        begin
            abs_reg[k]  <= src[k][ABS_W-1] ? ABS_W'(-src[k]) : ABS_W'(src[k]);
            neg1_reg[k] <= src[k][ABS_W-1];
        end

        // stage 2: reciprocal estimate of the remainder part
        always_ff @(posedge clk)
        begin
            q0_reg[k]   <= ABS_W'((60'(abs_reg[k]) * 60'(RECIP_M)) >> 30);
            a2_reg[k]   <= abs_reg[k];
            neg2_reg[k] <= neg1_reg[k];
        end

        // stage 3: correct the estimate by one, add the whole part, apply sign
        always_comb
        begin
            r  = PR_W'(a2_reg[k]) * PR_W'(PH_RK) - PR_W'(q0_reg[k]) * PR_W'(45);
            q1 = PH_W'(q0_reg[k]) + ((r >= PR_W'(45)) ? 32'd1 : 32'd0);
            q  = PH_W'(a2_reg[k]) * PH_W'(PH_QK) + q1;
        end

        always_ff @(posedge clk)
        begin
            phase_reg[k] <= neg2_reg[k] ? -q : q;
        end

        gcb_sincos u_sincos (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (v3_reg),
            .phase     (phase_reg[k]),
            .out_valid (sc_v[k]),
            .sin_q     (sin_w[k]),
            .cos_q     (cos_w[k])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start_ok;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign sc_valid = &sc_v;

    // products: y = sd*c2, t = s1*c2, c1*s2, then t*cd, then x
    assign p_y  = sin_w[2] * cos_w[1];
    assign p_t  = sin_w[0] * cos_w[1];
    assign p_x  = cos_w[0] * sin_w[1];
    assign p_tc = t_reg * cd_reg;

    always_ff @(posedge clk)
    begin
        my_reg   <= p_y[PR_W+29:30];
        t_reg    <= p_t[SC_W+29:30];
        c1s2_reg <= p_x[PR_W+29:30];
        cd_reg   <= cos_w[2];
        tc_reg   <= p_tc[PR_W+29:30];
        y2_reg   <= my_reg;
        x1_reg   <= c1s2_reg;
        y3_reg   <= y2_reg;
        x3_reg   <= x1_reg - tc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_v_reg <= 1'b0;
            m2_v_reg <= 1'b0;
            m3_v_reg <= 1'b0;
        end
        else
        begin
            m1_v_reg <= sc_valid;
            m2_v_reg <= m1_v_reg;
            m3_v_reg <= m2_v_reg;
        end
    end

    gcb_atan2 u_atan2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (m3_v_reg),
        .y_in      (y3_reg),
        .x_in      (x3_reg),
        .out_valid (done),
        .deg       (bearing_deg)
    );
endmodule
`default_nettype wire

FILE: sv/gcb_checker.sv
`default_nettype none
module gcb_checker import gcb_pkg::*; (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic               done,
    input wire logic signed [8:0]  bearing_deg
);
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

    a_start_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##GCB_LATENCY done)
        else $error("accepted beat gave no result");

    a_done_has_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, GCB_LATENCY))
        else $error("result without an accepted beat");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (bearing_deg >= -9'sd180) && (bearing_deg <= 9'sd180))
        else $error("bearing out of range");
endmodule

bind great_circle_bearing_core gcb_checker u_gcb_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .bearing_deg (bearing_deg)
);
`default_nettype wire
